>>> src/fls_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fls_pkg
// Shared widths and types for the frame level statistics block.
// ----------------------------------------------------------------------------
package fls_pkg;

  localparam int unsigned SampleW   = 16;
  localparam int unsigned MeanW     = 16;
  localparam int unsigned CountOutW = 11;
  // Quotient is at most 32768, so 16 restoring steps cover it.
  localparam int unsigned QuotW     = 16;
  localparam int unsigned StepW     = $clog2(QuotW);

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

>>> src/fls_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fls_front
// Per-sample accumulator: running min/max, absolute sum and count; pushes
// one frame summary word into the queue on the last sample of a frame.
// ----------------------------------------------------------------------------
module fls_front #(
  parameter int unsigned MAX_FRAME = 1024,
  parameter int unsigned CNT_W     = 11,
  parameter int unsigned SUM_W     = 27,
  parameter int unsigned ENT_W     = 33 + SUM_W + CNT_W
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [fls_pkg::SampleW-1:0] sample_i,
  input  logic                          last_i,
  input  fls_pkg::q_status_t            q_status_i,
  output logic                          push_o,
  output logic [ENT_W-1:0]              push_data_o
);
  import fls_pkg::*;

  localparam logic [CNT_W-1:0] MaxCnt = CNT_W'(MAX_FRAME);

  logic signed [SampleW-1:0] min_q, min_d, max_q, max_d;
  logic [SUM_W-1:0]          sum_q, sum_d;
  logic [CNT_W-1:0]          cnt_q, cnt_d;
  logic                      open_q, ovf_q, ovf_d;
  logic [SampleW-1:0]        mag;
  logic                      accept, sat;

  assign in_stall_o = q_status_i.full;
  assign accept     = in_valid_i && !in_stall_o;
  assign push_o     = accept && last_i;

  // -32768 maps to 32768 as an unsigned 16-bit value
  assign mag = sample_i[SampleW-1] ? (~sample_i + SampleW'(1)) : sample_i;
  assign sat = (cnt_q == MaxCnt);

  always_comb begin
    min_d = sample_i;
    max_d = sample_i;
    if (open_q) begin
      min_d = (sample_i < min_q) ? sample_i : min_q;
      max_d = (sample_i > max_q) ? sample_i : max_q;
    end
    if (sat) begin
      sum_d = sum_q;
      cnt_d = cnt_q;
      ovf_d = 1'b1;
    end else begin
      sum_d = sum_q + SUM_W'(mag);
      cnt_d = cnt_q + CNT_W'(1);
      ovf_d = ovf_q;
    end
  end

  assign push_data_o = {min_d, max_d, sum_d, cnt_d, ovf_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q  <= '0;
      max_q  <= '0;
      sum_q  <= '0;
      cnt_q  <= '0;
      open_q <= 1'b0;
      ovf_q  <= 1'b0;
    end else if (accept) begin
      if (last_i) begin
        min_q  <= '0;
        max_q  <= '0;
        sum_q  <= '0;
        cnt_q  <= '0;
        open_q <= 1'b0;
        ovf_q  <= 1'b0;
      end else begin
        min_q  <= min_d;
        max_q  <= max_d;
        sum_q  <= sum_d;
        cnt_q  <= cnt_d;
        open_q <= 1'b1;
        ovf_q  <= ovf_d;
      end
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= MaxCnt)
    else $error("frame count above bound");

  a_open_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !open_q |-> (cnt_q == '0 && !ovf_q))
    else $error("closed frame holds stale count");

endmodule

>>> src/fls_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fls_queue
// Two-entry queue of frame summary words between front and back.
// ----------------------------------------------------------------------------
module fls_queue #(
  parameter int unsigned WIDTH = 72
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  logic [WIDTH-1:0]   push_data_i,
  input  logic               pop_i,
  output logic [WIDTH-1:0]   pop_data_o,
  output fls_pkg::q_status_t status_o
);
  import fls_pkg::*;

  logic [WIDTH-1:0] mem_q [2];
  logic             wr_ptr_q, rd_ptr_q;
  logic [1:0]       fill_q;

  assign status_o.full  = (fill_q == 2'd2);
  assign status_o.empty = (fill_q == 2'd0);
  assign pop_data_o     = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop_i)  rd_ptr_q <= ~rd_ptr_q;
      if (push_i && !pop_i)      fill_q <= fill_q + 2'd1;
      else if (pop_i && !push_i) fill_q <= fill_q - 2'd1;
    end
  end

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !status_o.full)
    else $error("push into full queue");

  a_no_underrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !status_o.empty)
    else $error("pop from empty queue");

endmodule

>>> src/fls_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fls_back
// Takes one frame summary word, divides sum by count one quotient bit per
// cycle and holds the result in the output register.
// ----------------------------------------------------------------------------
module fls_back #(
  parameter int unsigned CNT_W = 11,
  parameter int unsigned SUM_W = 27,
  parameter int unsigned ENT_W = 33 + SUM_W + CNT_W
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  fls_pkg::q_status_t                 q_status_i,
  input  logic [ENT_W-1:0]                   pop_data_i,
  output logic                               pop_o,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [fls_pkg::SampleW-1:0] frame_min_o,
  output logic signed [fls_pkg::SampleW-1:0] frame_max_o,
  output logic [fls_pkg::MeanW-1:0]          mean_abs_o,
  output logic [fls_pkg::CountOutW-1:0]      sample_count_o,
  output logic                               overflow_o
);
  import fls_pkg::*;

  typedef enum logic [1:0] {
    StIdle,
    StDiv,
    StHold
  } state_e;

  state_e                    state_q;
  logic signed [SampleW-1:0] min_q, max_q;
  logic [CNT_W-1:0]          cnt_q;
  logic                      ovf_q;
  logic [SUM_W-1:0]          rem_q, div_q, rem_diff;
  logic [QuotW-1:0]          quo_q;
  logic [StepW-1:0]          step_q;
  logic                      ge;
  logic                      out_valid_q, slot_free;
  logic signed [SampleW-1:0] e_min, e_max;
  logic [SUM_W-1:0]          e_sum;
  logic [CNT_W-1:0]          e_cnt;
  logic                      e_ovf;
  logic [CNT_W+CountOutW-1:0] cnt_ext;

  assign {e_min, e_max, e_sum, e_cnt, e_ovf} = pop_data_i;

  assign pop_o     = (state_q == StIdle) && !q_status_i.empty;
  assign ge        = (rem_q >= div_q);
  assign rem_diff  = rem_q - div_q;
  assign slot_free = !out_valid_q || !out_stall_i;
  // count field is masked to its port width
  assign cnt_ext   = (CNT_W + CountOutW)'(cnt_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= StIdle;
      out_valid_q    <= 1'b0;
      step_q         <= '0;
      min_q          <= '0;
      max_q          <= '0;
      cnt_q          <= '0;
      ovf_q          <= 1'b0;
      rem_q          <= '0;
      div_q          <= '0;
      quo_q          <= '0;
      frame_min_o    <= '0;
      frame_max_o    <= '0;
      mean_abs_o     <= '0;
      sample_count_o <= '0;
      overflow_o     <= 1'b0;
    end else begin
      if (state_q == StHold && slot_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          if (pop_o) begin
            min_q   <= e_min;
            max_q   <= e_max;
            cnt_q   <= e_cnt;
            ovf_q   <= e_ovf;
            rem_q   <= e_sum;
            // divisor aligned to the top quotient bit
            div_q   <= SUM_W'(e_cnt) << (QuotW - 1);
            step_q  <= StepW'(QuotW - 1);
            state_q <= StDiv;
          end
        end
        StDiv: begin
          if (ge) rem_q <= rem_diff;
          quo_q  <= {quo_q[QuotW-2:0], ge};
          div_q  <= div_q >> 1;
          step_q <= step_q - StepW'(1);
          if (step_q == '0) state_q <= StHold;
        end
        StHold: begin
          if (slot_free) begin
            frame_min_o    <= min_q;
            frame_max_o    <= max_q;
            mean_abs_o     <= quo_q;
            sample_count_o <= cnt_ext[CountOutW-1:0];
            overflow_o     <= ovf_q;
            state_q        <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;

  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDiv) |-> ({1'b0, rem_q} < {div_q, 1'b0}))
    else $error("partial remainder exceeds quotient range");

  a_nonzero_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> (e_cnt != '0))
    else $error("frame summary with zero count");

endmodule

>>> src/frame_level_statistics.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_level_statistics
// Per-frame min, max, mean absolute level and sample count of a PCM stream.
// ----------------------------------------------------------------------------
// Samples: one word per cycle into the accumulator while in_stall_o is low, no gaps needed.
// Frame result: when the back end is free, a queue pop, 16 restoring divide
//   steps and an output load.
// Back end works on one frame summary at a time; a two-deep summary queue
//   absorbs frames that end while it is busy, past that the sample input stalls.
// Reset (async, active low) clears the open frame, the queue and the output.
module frame_level_statistics #(
  parameter int unsigned MAX_FRAME = 1024
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic signed [fls_pkg::SampleW-1:0] sample_i,
  input  logic                               last_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [fls_pkg::SampleW-1:0] frame_min_o,
  output logic signed [fls_pkg::SampleW-1:0] frame_max_o,
  output logic [fls_pkg::MeanW-1:0]          mean_abs_o,
  output logic [fls_pkg::CountOutW-1:0]      sample_count_o,
  output logic                               overflow_o
);
  import fls_pkg::*;

  localparam int unsigned CntW = $clog2(MAX_FRAME + 1);
  localparam int unsigned SumW = SampleW + CntW;
  localparam int unsigned EntW = 2 * SampleW + SumW + CntW + 1;

  q_status_t        q_status;
  logic             push, pop;
  logic [EntW-1:0]  push_data, pop_data;

  fls_front #(
    .MAX_FRAME (MAX_FRAME),
    .CNT_W     (CntW),
    .SUM_W     (SumW),
    .ENT_W     (EntW)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .sample_i    (sample_i),
    .last_i      (last_i),
    .q_status_i  (q_status),
    .push_o      (push),
    .push_data_o (push_data)
  );

  fls_queue #(
    .WIDTH (EntW)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .status_o    (q_status)
  );

  fls_back #(
    .CNT_W (CntW),
    .SUM_W (SumW),
    .ENT_W (EntW)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_status_i     (q_status),
    .pop_data_i     (pop_data),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .frame_min_o    (frame_min_o),
    .frame_max_o    (frame_max_o),
    .mean_abs_o     (mean_abs_o),
    .sample_count_o (sample_count_o),
    .overflow_o     (overflow_o)
  );

endmodule
